// ===== hw/rtl/cts_pkg.sv =====
// Shared constants, codes and types of the capability tag store.
// Used by the channel interfaces and by the top level; depends on nothing.
package cts_pkg;

   // Address space and granule geometry.
   localparam int ADDR_BITS     = 20;
   localparam int GRAN_LOG2     = 4;
   localparam int GRAN_BYTES    = 1 << GRAN_LOG2;
   localparam int GRAN_BITS     = ADDR_BITS - GRAN_LOG2;

   // One memory row holds the granules of the largest line.
   localparam int ROW_LOG2      = 4;
   localparam int ROW_GRANULES  = 1 << ROW_LOG2;
   localparam int ROW_BITS      = GRAN_BITS - ROW_LOG2;
   localparam int ROW_DEPTH     = 1 << ROW_BITS;
   localparam int ROW_WIDTH     = 2 * ROW_GRANULES;

   // Field widths of the channels.
   localparam int SIZE_BITS     = 7;
   localparam int CFG_BITS      = 3;

   // Line size register: reset value and saturation limit.
   localparam logic [CFG_BITS-1:0] LINE_LOG2_RESET = 3'd2;
   localparam logic [CFG_BITS-1:0] MAX_LINE_LOG2   = 3'd4;

   typedef enum logic [1:0] {
      FUNC_MARK   = 2'd0,
      FUNC_FETCH  = 2'd1,
      FUNC_DATA   = 2'd2,
      FUNC_LOOKUP = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RMW_RD,
      ST_RMW_WR,
      ST_LK_RD,
      ST_LK_DATA
   } state_type;

   // One memory row: a known bit and a tag bit for each granule.
   typedef struct packed {
      logic [ROW_GRANULES-1:0] known;
      logic [ROW_GRANULES-1:0] tag;
   } row_type;

endpackage

// ===== hw/rtl/cts_if.sv =====
// Valid/ready channel interfaces of the capability tag store.
// Depends on cts_pkg for field widths and the function code type.
interface cts_req_if import cts_pkg::*; ;
   logic                  valid;
   logic                  ready;
   func_type              func;
   logic                  marker_tag;
   logic [ADDR_BITS-1:0]  address;
   logic [SIZE_BITS-1:0]  access_size;

   modport source (output valid, output func, output marker_tag, output address,
                   output access_size, input ready);
   modport sink   (input valid, input func, input marker_tag, input address,
                   input access_size, output ready);
endinterface

interface cts_rsp_if import cts_pkg::*; ;
   logic                     valid;
   logic                     ready;
   logic [ADDR_BITS-1:0]     line_address;
   logic [ROW_GRANULES-1:0]  tag_bits;
   logic [ROW_GRANULES-1:0]  known_bits;
   logic                     straddle_error;

   modport source (output valid, output line_address, output tag_bits,
                   output known_bits, output straddle_error, input ready);
   modport sink   (input valid, input line_address, input tag_bits,
                   input known_bits, input straddle_error, output ready);
endinterface

interface cts_csr_if import cts_pkg::*; ;
   logic                 valid;
   logic                 ready;
   logic [CFG_BITS-1:0]  line_granules_log2;

   modport source (output valid, output line_granules_log2, input ready);
   modport sink   (input valid, input line_granules_log2, output ready);
endinterface

// ===== hw/rtl/cts_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Stand-alone; no package dependency.
module cts_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Read every cycle; a read of the row being written returns the old word.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// ===== hw/rtl/capability_tag_store.sv =====
// Top level of the capability tag store, built around one tag RAM.
// Depends on cts_pkg, the channel interfaces in cts_if.sv and cts_ram.
//
// The store keeps a known bit and a tag bit for every 16-byte granule of a
// 20-bit address space, packed as 4096 rows of 16 granules, so any cache line
// of up to 16 granules sits in a single row. After reset the block runs a
// clearing pass that writes one row per cycle and takes no word on req_ch
// until it finishes; csr_ch writes are taken at any time. Items are handled
// one at a time. A fetch or a data access reads, merges and writes back each
// row it touches, in turn; a fetch or data access that writes no granule
// skips the read and the write-back. A line lookup reads one row, then waits
// while an earlier lookup result still waits on rsp_ch.
// The next request is taken while a lookup result still waits on rsp_ch.
module capability_tag_store import cts_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   cts_csr_if.sink   csr_ch,
   cts_req_if.sink   req_ch,
   cts_rsp_if.source rsp_ch
);

   state_type state_ff, state_in;

   logic [CFG_BITS-1:0]     line_log2_ff;
   logic                    pend_valid_ff, pend_valid_in;
   logic                    pend_tag_ff, pend_tag_in;

   // Current item: row address, granule mask over two rows, write tag.
   logic [ROW_BITS-1:0]     row_ff, row_in;
   logic [ROW_WIDTH-1:0]    mask_ff, mask_in;
   logic                    wtag_ff, wtag_in;

   // Current lookup: first granule in the row, lane mask, line base, straddle.
   logic [ROW_LOG2-1:0]     col_ff, col_in;
   logic [ROW_GRANULES-1:0] lanes_ff, lanes_in;
   logic [ADDR_BITS-1:0]    line_ff, line_in;
   logic                    strad_ff, strad_in;

   // Result word register.
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [ADDR_BITS-1:0]    rsp_line_ff, rsp_line_in;
   logic [ROW_GRANULES-1:0] rsp_tag_ff, rsp_tag_in;
   logic [ROW_GRANULES-1:0] rsp_known_ff, rsp_known_in;
   logic                    rsp_strad_ff, rsp_strad_in;

   // RAM ports.
   logic                    ram_wr_en;
   logic [ROW_WIDTH-1:0]    ram_wr_data;
   logic [ROW_WIDTH-1:0]    ram_rd_data;
   row_type                 rd_row;
   row_type                 merged_row;

   // Request decode.
   logic                    req_accept;
   logic                    rsp_free;
   logic [CFG_BITS-1:0]     lg_sat;
   logic [ADDR_BITS:0]      end_addr;
   logic [ADDR_BITS:0]      end_up;
   logic [GRAN_BITS:0]      gran_count;
   logic [ROW_GRANULES:0]   span_ones;
   logic [ROW_WIDTH-1:0]    acc_mask;
   logic [ROW_LOG2-1:0]     acc_col;
   logic [ADDR_BITS:0]      line_bytes;
   logic [3:0]              line_shift;
   logic [ADDR_BITS:0]      line_first;
   logic [ADDR_BITS:0]      line_last;
   logic [ROW_LOG2:0]       gran_lo_mask;
   logic [ROW_LOG2:0]       line_granules;
   logic [ROW_GRANULES:0]   lane_ones;
   logic [ROW_GRANULES-1:0] tag_shift;
   logic [ROW_GRANULES-1:0] known_shift;

   cts_ram #(
      .WIDTH (ROW_WIDTH),
      .DEPTH (ROW_DEPTH)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (row_ff),
      .wr_data (ram_wr_data),
      .rd_addr (row_ff),
      .rd_data (ram_rd_data)
   );

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_accept   = req_ch.valid && req_ch.ready;
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;
   assign csr_ch.ready = 1'b1;

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.line_address   = rsp_line_ff;
   assign rsp_ch.tag_bits       = rsp_tag_ff;
   assign rsp_ch.known_bits     = rsp_known_ff;
   assign rsp_ch.straddle_error = rsp_strad_ff;

   // Granule span of an access: from the address rounded down to a granule up
   // to the end address rounded up; at most nine granules, so at most two rows.
   always_comb begin
      end_addr   = {1'b0, req_ch.address} + (ADDR_BITS + 1)'(req_ch.access_size);
      end_up     = end_addr + (ADDR_BITS + 1)'(GRAN_BYTES - 1);
      gran_count = end_up[ADDR_BITS:GRAN_LOG2] - {1'b0, req_ch.address[ADDR_BITS-1:GRAN_LOG2]};
      span_ones  = ((ROW_GRANULES + 1)'(1) << gran_count[ROW_LOG2-1:0])
                   - (ROW_GRANULES + 1)'(1);
      acc_col    = req_ch.address[GRAN_LOG2+ROW_LOG2-1:GRAN_LOG2];
      acc_mask   = ROW_WIDTH'(span_ones[ROW_GRANULES-1:0]) << acc_col;
   end

   // Line geometry of a lookup, with the line size register saturated.
   always_comb begin
      lg_sat        = (line_log2_ff > MAX_LINE_LOG2) ? MAX_LINE_LOG2 : line_log2_ff;
      line_bytes    = (ADDR_BITS + 1)'(GRAN_BYTES) << lg_sat;
      line_shift    = 4'(GRAN_LOG2) + 4'(lg_sat);
      line_in       = req_ch.address & ~(line_bytes[ADDR_BITS-1:0] - ADDR_BITS'(1));
      line_first    = {1'b0, req_ch.address} >> line_shift;
      line_last     = (end_addr + line_bytes - (ADDR_BITS + 1)'(1)) >> line_shift;
      strad_in      = (line_last - line_first) != (ADDR_BITS + 1)'(1);
      gran_lo_mask  = ((ROW_LOG2 + 1)'(1) << lg_sat) - (ROW_LOG2 + 1)'(1);
      col_in        = acc_col & ~gran_lo_mask[ROW_LOG2-1:0];
      line_granules = (ROW_LOG2 + 1)'(1) << lg_sat;
      lane_ones     = ((ROW_GRANULES + 1)'(1) << line_granules) - (ROW_GRANULES + 1)'(1);
      lanes_in      = lane_ones[ROW_GRANULES-1:0];
   end

   // Merge of the read row with the granules of the current access.
   always_comb begin
      rd_row           = row_type'(ram_rd_data);
      merged_row.known = rd_row.known | mask_ff[ROW_GRANULES-1:0];
      merged_row.tag   = (rd_row.tag & ~mask_ff[ROW_GRANULES-1:0])
                         | (mask_ff[ROW_GRANULES-1:0] & {ROW_GRANULES{wtag_ff}});
      tag_shift        = rd_row.tag >> col_ff;
      known_shift      = rd_row.known >> col_ff;
   end

   // Next state and datapath control.
   always_comb begin
      state_in      = state_ff;
      pend_valid_in = pend_valid_ff;
      pend_tag_in   = pend_tag_ff;
      row_in        = row_ff;
      mask_in       = mask_ff;
      wtag_in       = wtag_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_line_in   = rsp_line_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_known_in  = rsp_known_ff;
      rsp_strad_in  = rsp_strad_ff;
      ram_wr_en     = 1'b0;
      ram_wr_data   = merged_row;

      unique case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_data = '0;
            row_in      = row_ff + ROW_BITS'(1);
            if (row_ff == {ROW_BITS{1'b1}}) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               row_in  = req_ch.address[ADDR_BITS-1:ADDR_BITS-ROW_BITS];
               mask_in = acc_mask;
               unique case (req_ch.func)
                  FUNC_MARK: begin
                     pend_valid_in = 1'b1;
                     pend_tag_in   = req_ch.marker_tag;
                  end
                  FUNC_FETCH: begin
                     pend_valid_in = 1'b0;
                     pend_tag_in   = 1'b0;
                     wtag_in       = 1'b0;
                     if (acc_mask != '0) begin
                        state_in = ST_RMW_RD;
                     end
                  end
                  FUNC_DATA: begin
                     pend_valid_in = 1'b0;
                     pend_tag_in   = 1'b0;
                     wtag_in       = pend_tag_ff;
                     if (pend_valid_ff && (acc_mask != '0)) begin
                        state_in = ST_RMW_RD;
                     end
                  end
                  FUNC_LOOKUP: begin
                     state_in = ST_LK_RD;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_RMW_RD: begin
            state_in = ST_RMW_WR;
         end
         ST_RMW_WR: begin
            // Write back this row, then move on to the spill row if any.
            ram_wr_en = 1'b1;
            if (mask_ff[ROW_WIDTH-1:ROW_GRANULES] != '0) begin
               mask_in  = {{ROW_GRANULES{1'b0}}, mask_ff[ROW_WIDTH-1:ROW_GRANULES]};
               row_in   = row_ff + ROW_BITS'(1);
               state_in = ST_RMW_RD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_LK_RD: begin
            state_in = ST_LK_DATA;
         end
         ST_LK_DATA: begin
            // The RAM keeps reading the same row, so the data holds while we wait.
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_line_in  = line_ff;
               rsp_tag_in   = tag_shift & known_shift & lanes_ff;
               rsp_known_in = known_shift & lanes_ff;
               rsp_strad_in = strad_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         row_ff        <= '0;
         pend_valid_ff <= 1'b0;
         pend_tag_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         line_log2_ff  <= LINE_LOG2_RESET;
      end else begin
         state_ff      <= state_in;
         row_ff        <= row_in;
         pend_valid_ff <= pend_valid_in;
         pend_tag_ff   <= pend_tag_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_ch.valid && csr_ch.ready) begin
            line_log2_ff <= csr_ch.line_granules_log2;
         end
      end
   end

   // Payload registers of the current item and of the result word.
   always_ff @(posedge clock) begin
      mask_ff      <= mask_in;
      wtag_ff      <= wtag_in;
      rsp_line_ff  <= rsp_line_in;
      rsp_tag_ff   <= rsp_tag_in;
      rsp_known_ff <= rsp_known_in;
      rsp_strad_ff <= rsp_strad_in;
      if (req_accept) begin
         col_ff   <= col_in;
         lanes_ff <= lanes_in;
         line_ff  <= line_in;
         strad_ff <= strad_in;
      end
   end

endmodule

// ===== sim/capability_tag_store_tb.sv =====
// Self-checking testbench for capability_tag_store: random and directed words
// on req_ch, lookups checked on rsp_ch against an in-bench tag store predictor.
// Depends on cts_pkg, the channel interfaces in cts_if.sv and the RTL top level.
module capability_tag_store_tb import cts_pkg::*; ;

   localparam int IDLE_PERCENT  = 19;
   localparam int HOLD_AFTER    = 40;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 24;
   localparam int STALL_LIMIT   = 20000;
   localparam int PHASE_ITEMS   = 241;
   localparam int unsigned ADDR_MASK  = (1 << ADDR_BITS) - 1;
   localparam int unsigned ADDR_TOP   = ADDR_MASK;
   localparam int unsigned STORE_SIZE = 1 << GRAN_BITS;
   localparam logic [1:0] GRANULE_KNOWN  = 2'b10;
   localparam logic [1:0] GRANULE_TAGGED = 2'b01;

   typedef struct packed {
      func_type              func;
      logic                  marker_tag;
      logic [ADDR_BITS-1:0]  address;
      logic [SIZE_BITS-1:0]  access_size;
   } tag_request_type;

   typedef struct packed {
      logic [ADDR_BITS-1:0]     line_address;
      logic [ROW_GRANULES-1:0]  tag_bits;
      logic [ROW_GRANULES-1:0]  known_bits;
      logic                     straddle_error;
   } line_report_type;

   logic clock = 1'b0;
   logic reset;

   cts_req_if req_ch ();
   cts_rsp_if rsp_ch ();
   cts_csr_if csr_ch ();

   capability_tag_store dut (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Predictor state: per granule a known bit (bit 1) and a tag bit (bit 0).
   logic [1:0]          granule_state [STORE_SIZE];
   logic                tag_pending;
   logic                pending_marker_tag;
   logic [CFG_BITS-1:0] line_log2_setting;

   tag_request_type pending_requests [$];
   line_report_type expected_lines [$];
   tag_request_type offered;

   int  requests_queued = 0;
   int  requests_taken  = 0;
   int  lookups_seen    = 0;
   int  failures        = 0;
   int  stall_cycles    = 0;
   int  hold_left       = 0;
   bit  hold_done       = 1'b0;
   int  cycle_count     = 0;
   logic calm;

   // Calm stretches, which recur with cycle_count, in which neither side idles.
   assign calm = (cycle_count % 5000) >= 4000;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Write one value into every granule that an access touches.
   function automatic void mark_span(input logic [ADDR_BITS-1:0] address,
                                     input logic [SIZE_BITS-1:0] size,
                                     input logic [1:0] value);
      int unsigned first;
      int unsigned stop;
      int unsigned a;
      first = address - (address % GRAN_BYTES);
      stop  = ((address + size + GRAN_BYTES - 1) / GRAN_BYTES) * GRAN_BYTES;
      for (a = first; a < stop; a += GRAN_BYTES)
         granule_state[GRAN_BITS'((a & ADDR_MASK) / GRAN_BYTES)] = value;
   endfunction

   // Build the report of the line that holds the looked-up address.
   function automatic line_report_type report_line(input tag_request_type item);
      line_report_type report;
      int unsigned  lg;
      int unsigned  line_bytes;
      int unsigned  first;
      int unsigned  stop;
      logic [1:0]   entry;
      lg = 32'((line_log2_setting > MAX_LINE_LOG2) ? MAX_LINE_LOG2 : line_log2_setting);
      line_bytes = GRAN_BYTES << lg;
      first = item.address - (item.address % line_bytes);
      stop  = ((item.address + item.access_size + line_bytes - 1) / line_bytes)
              * line_bytes;
      report = '0;
      report.line_address = ADDR_BITS'(first);
      for (int i = 0; i < (1 << lg); i++) begin
         entry = granule_state[GRAN_BITS'(((first + i * GRAN_BYTES) & ADDR_MASK)
                                          / GRAN_BYTES)];
         if (entry & GRANULE_KNOWN) begin
            report.known_bits[ROW_LOG2'(i)] = 1'b1;
            report.tag_bits[ROW_LOG2'(i)]   = (entry & GRANULE_TAGGED) != 0;
         end
      end
      report.straddle_error = (stop - first) != line_bytes;
      return report;
   endfunction

   // Advance the predictor by one accepted request word.
   function automatic void apply_tag_request(input tag_request_type item);
      case (item.func)
         FUNC_MARK: begin
            tag_pending        = 1'b1;
            pending_marker_tag = item.marker_tag;
         end
         FUNC_FETCH: begin
            mark_span(item.address, item.access_size, GRANULE_KNOWN);
            tag_pending        = 1'b0;
            pending_marker_tag = 1'b0;
         end
         FUNC_DATA: begin
            if (tag_pending)
               mark_span(item.address, item.access_size,
                         pending_marker_tag ? (GRANULE_KNOWN | GRANULE_TAGGED)
                                            : GRANULE_KNOWN);
            tag_pending        = 1'b0;
            pending_marker_tag = 1'b0;
         end
         default: begin
            expected_lines.push_back(report_line(item));
         end
      endcase
   endfunction

   // Compare one lookup word against the oldest expected line report.
   function automatic void check_line_report();
      line_report_type want;
      if (expected_lines.size() == 0) begin
         $error("unexpected lookup word: line_address %h", rsp_ch.line_address);
         failures++;
         return;
      end
      want = expected_lines.pop_front();
      if (rsp_ch.line_address !== want.line_address) begin
         $error("line_address: expected %h, actual %h", want.line_address,
                rsp_ch.line_address);
         failures++;
      end
      if (rsp_ch.tag_bits !== want.tag_bits) begin
         $error("tag_bits: expected %h, actual %h", want.tag_bits, rsp_ch.tag_bits);
         failures++;
      end
      if (rsp_ch.known_bits !== want.known_bits) begin
         $error("known_bits: expected %h, actual %h", want.known_bits,
                rsp_ch.known_bits);
         failures++;
      end
      if (rsp_ch.straddle_error !== want.straddle_error) begin
         $error("straddle_error: expected %b, actual %b", want.straddle_error,
                rsp_ch.straddle_error);
         failures++;
      end
   endfunction

   // Request driver: offers queued words, idling at random between them.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            apply_tag_request(offered);
            requests_taken++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (pending_requests.size() > 0 &&
                (calm || $urandom_range(99) >= IDLE_PERCENT)) begin
               offered = pending_requests.pop_front();
               req_ch.valid       <= 1'b1;
               req_ch.func        <= offered.func;
               req_ch.marker_tag  <= offered.marker_tag;
               req_ch.address     <= offered.address;
               req_ch.access_size <= offered.access_size;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Lookup monitor: checks each word and stalls at random; once it holds
   // off for a long stretch so that the block backs up into req_ch.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            check_line_report();
            lookups_seen++;
         end
         if (!hold_done && lookups_seen >= HOLD_AFTER) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   // Watchdog: ends the run when no channel moves a word for too long.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic queue_request(input func_type func, input logic marker_tag,
                                input int unsigned address, input int unsigned size);
      tag_request_type item;
      item.func        = func;
      item.marker_tag  = marker_tag;
      item.address     = ADDR_BITS'(address);
      item.access_size = SIZE_BITS'(size);
      pending_requests.push_back(item);
      requests_queued++;
   endtask

   // Mostly a small hot region near the bottom, some near the top so that
   // spans wrap, and a few anywhere.
   function automatic int unsigned pick_address();
      int r;
      r = $urandom_range(99);
      if (r < 70)
         return $urandom_range(0, 'h7FF);
      else if (r < 85)
         return ADDR_TOP - $urandom_range(0, 'h3FF);
      return $urandom_range(0, ADDR_TOP);
   endfunction

   function automatic int unsigned pick_size();
      int r;
      r = $urandom_range(99);
      if (r < 10)
         return 0;
      else if (r < 20)
         return 64;
      return $urandom_range(1, 63);
   endfunction

   function automatic logic pick_tag();
      return 1'($urandom_range(1));
   endfunction

   // Random phase: mostly marker-then-access sequences, fetches and lookups,
   // with some untagged accesses, marker chains and fully random words.
   task automatic queue_random_phase(input int count);
      int start;
      int r;
      start = requests_queued;
      while (requests_queued - start < count) begin
         r = $urandom_range(99);
         if (r < 32) begin
            queue_request(FUNC_MARK, pick_tag(), pick_address(), pick_size());
            queue_request(FUNC_DATA, pick_tag(), pick_address(), pick_size());
         end else if (r < 46) begin
            queue_request(FUNC_FETCH, pick_tag(), pick_address(), pick_size());
         end else if (r < 74) begin
            queue_request(FUNC_LOOKUP, pick_tag(), pick_address(), pick_size());
         end else if (r < 80) begin
            queue_request(FUNC_DATA, pick_tag(), pick_address(), pick_size());
         end else if (r < 86) begin
            queue_request(FUNC_MARK, pick_tag(), pick_address(), pick_size());
            queue_request(FUNC_FETCH, pick_tag(), pick_address(), pick_size());
         end else if (r < 90) begin
            queue_request(FUNC_MARK, pick_tag(), pick_address(), pick_size());
            queue_request(FUNC_MARK, pick_tag(), pick_address(), pick_size());
            queue_request(FUNC_DATA, pick_tag(), pick_address(), pick_size());
         end else if (r < 95) begin
            queue_request(FUNC_MARK, pick_tag(), pick_address(), pick_size());
            queue_request(FUNC_LOOKUP, pick_tag(), pick_address(), pick_size());
            queue_request(FUNC_DATA, pick_tag(), pick_address(), pick_size());
         end else begin
            queue_request(func_type'($urandom_range(3)), pick_tag(),
                          $urandom_range(0, ADDR_TOP), $urandom_range(0, 64));
         end
      end
   endtask

   // Wait until every queued word is taken and every lookup is back, then
   // give a trailing fetch or data access time to finish its write-back.
   task automatic drain();
      while (requests_taken != requests_queued || expected_lines.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_line_size(input logic [CFG_BITS-1:0] value);
      @(posedge clock);
      csr_ch.valid              <= 1'b1;
      csr_ch.line_granules_log2 <= value;
      do
         @(posedge clock);
      while (!csr_ch.ready);
      csr_ch.valid      <= 1'b0;
      line_log2_setting = value;
   endtask

   initial begin
      logic [CFG_BITS-1:0] line_settings [8];
      line_settings = '{3'd0, 3'd4, 3'd7, 3'd1, 3'd3, 3'd5, 3'd6, 3'd2};

      foreach (granule_state[i])
         granule_state[i] = 2'b00;
      tag_pending        = 1'b0;
      pending_marker_tag = 1'b0;
      line_log2_setting  = LINE_LOG2_RESET;

      reset                     = 1'b1;
      req_ch.valid              = 1'b0;
      req_ch.func               = FUNC_MARK;
      req_ch.marker_tag         = 1'b0;
      req_ch.address            = '0;
      req_ch.access_size        = '0;
      rsp_ch.ready              = 1'b0;
      csr_ch.valid              = 1'b0;
      csr_ch.line_granules_log2 = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part, run with the line size left at its reset value.
      // Zero-length lookup at a line boundary: all unknown and flagged.
      queue_request(FUNC_LOOKUP, 1'b0, 'h00000, 0);
      queue_request(FUNC_FETCH,  1'b0, 'h00010, 'h20);
      queue_request(FUNC_LOOKUP, 1'b0, 'h00000, 64);
      // Zero-length data access off a granule boundary touches one granule.
      queue_request(FUNC_MARK,   1'b1, 'h00000, 0);
      queue_request(FUNC_DATA,   1'b0, 'h00005, 0);
      queue_request(FUNC_LOOKUP, 1'b0, 'h00003, 1);
      // Data access with no tag pending changes nothing.
      queue_request(FUNC_DATA,   1'b1, 'h00030, 16);
      // A second marker replaces the pending tag.
      queue_request(FUNC_MARK,   1'b0, 'h00000, 0);
      queue_request(FUNC_MARK,   1'b1, 'h00000, 0);
      queue_request(FUNC_DATA,   1'b0, 'h00030, 16);
      // Fetch with tag one pending still marks untagged and clears the tag.
      queue_request(FUNC_MARK,   1'b1, 'h00000, 0);
      queue_request(FUNC_FETCH,  1'b0, 'h00040, 64);
      queue_request(FUNC_DATA,   1'b0, 'h00040, 16);
      queue_request(FUNC_LOOKUP, 1'b0, 'h00040, 64);
      // A lookup keeps the pending tag; then a data access wraps past the top.
      queue_request(FUNC_MARK,   1'b1, 'h00000, 0);
      queue_request(FUNC_LOOKUP, 1'b0, 'h00000, 64);
      queue_request(FUNC_DATA,   1'b0, 'hFFFF8, 16);
      queue_request(FUNC_LOOKUP, 1'b0, 'hFFFC0, 64);
      queue_request(FUNC_LOOKUP, 1'b0, 'h00000, 63);
      queue_request(FUNC_LOOKUP, 1'b0, 'h0003F, 2);
      // Zero-length fetch on a granule boundary touches nothing.
      queue_request(FUNC_FETCH,  1'b1, 'h00080, 0);
      queue_request(FUNC_LOOKUP, 1'b1, 'h00080, 1);
      queue_request(FUNC_LOOKUP, 1'b1, ADDR_TOP, 64);
      drain();

      // Random phases, each under a different line size register value.
      foreach (line_settings[p]) begin
         write_line_size(line_settings[p]);
         queue_random_phase(PHASE_ITEMS);
         drain();
      end

      if (failures == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// ===== capability_tag_store.f =====
hw/rtl/cts_pkg.sv
hw/rtl/cts_if.sv
hw/rtl/cts_ram.sv
hw/rtl/capability_tag_store.sv
sim/capability_tag_store_tb.sv
